/* hdl/rlfe_pkg.sv */
// ----------------------------------------------------------------------------
// rlfe_pkg
// Shared types and constants of the raster line and fill engine: operation
// codes, sequencer states, field widths and configuration register indexes.
// ----------------------------------------------------------------------------
package rlfe_pkg;

  // field widths
  localparam int unsigned COORD_W = 6;
  localparam int unsigned SIZE_W  = 7;
  localparam int unsigned CHAN_W  = 8;
  localparam int unsigned COLOR_W = 3 * CHAN_W;
  localparam int unsigned OP_W    = 2;
  localparam int unsigned ERR_W   = 8;

  // configuration register indexes
  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  // operation codes
  typedef enum logic [OP_W-1:0] {
    OP_FILL = 2'd0,
    OP_LINE = 2'd1,
    OP_READ = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_FILL,
    S_LINE,
    S_READ,
    S_RDATA,
    S_RESULT
  } state_t;

  typedef logic signed [ERR_W-1:0] err_t;

endpackage

/* hdl/raster_line_and_fill_engine_core.sv */
// ----------------------------------------------------------------------------
// raster_line_and_fill_engine_core
// RGB frame store with a small sequencer that fills the active area, draws
// black Bresenham lines and reads single pixels, one request at a time.
// ----------------------------------------------------------------------------
//
//  channel    signals                          direction  notes
//  request    req_valid / req_stall + fields   in         operation, points, color
//  response   rsp_valid / rsp_stall + fields   out        pixel, clipped, done_res
//  config     cfg_write / cfg_index / cfg_data in         image_width, image_height
//
// A fill writes every pixel of the active area, a line walks its points and a
// read passes S_READ and S_RDATA (w, h = active size). The single-port frame
// store takes one pixel per cycle; the step logic walks one point a cycle.
// Reset is synchronous, clears control state and loads 64 into both size
// registers; the frame store is not cleared. A stalled response holds in the
// output register; the sequencer waits with the next result until it is taken.
//
module raster_line_and_fill_engine_core #(
  parameter int unsigned MAX_WIDTH  = 64,
  parameter int unsigned MAX_HEIGHT = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  // configuration
  input  logic                        cfg_write,
  input  logic                        cfg_index,
  input  logic [rlfe_pkg::SIZE_W-1:0] cfg_data,
  // request
  input  logic                        req_valid,
  output logic                        req_stall,
  input  logic [rlfe_pkg::OP_W-1:0]   operation,
  input  logic [rlfe_pkg::COORD_W-1:0] start_x,
  input  logic [rlfe_pkg::COORD_W-1:0] start_y,
  input  logic [rlfe_pkg::COORD_W-1:0] end_x,
  input  logic [rlfe_pkg::COORD_W-1:0] end_y,
  input  logic [rlfe_pkg::CHAN_W-1:0] fill_red,
  input  logic [rlfe_pkg::CHAN_W-1:0] fill_green,
  input  logic [rlfe_pkg::CHAN_W-1:0] fill_blue,
  // response
  output logic                        rsp_valid,
  input  logic                        rsp_stall,
  output logic [rlfe_pkg::CHAN_W-1:0] pixel_red,
  output logic [rlfe_pkg::CHAN_W-1:0] pixel_green,
  output logic [rlfe_pkg::CHAN_W-1:0] pixel_blue,
  output logic                        clipped,
  output logic                        done_res
);
  import rlfe_pkg::*;

  localparam int unsigned DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned ADDR_W = $clog2(DEPTH);

  // configuration registers and active size
  logic [SIZE_W-1:0] image_width;
  logic [SIZE_W-1:0] image_height;
  logic [SIZE_W-1:0] act_w;
  logic [SIZE_W-1:0] act_h;

  // sequencer
  state_t state;
  state_t state_next;

  // walk registers (fill counters and line position share them)
  logic [SIZE_W-1:0]  walk_x;
  logic [SIZE_W-1:0]  walk_y;
  err_t               error_term;
  logic [COORD_W-1:0] goal_x;
  logic [COORD_W-1:0] goal_y;
  logic [COORD_W-1:0] delta_x;
  logic [COORD_W-1:0] delta_y;
  logic               x_down;
  logic               y_down;
  logic [COLOR_W-1:0] fill_color;

  // pending result
  logic [COLOR_W-1:0] res_pix;
  logic               res_clip;
  logic               res_done;

  // frame store
  logic [COLOR_W-1:0] frame_store [DEPTH];
  logic [COLOR_W-1:0] rd_data;
  logic [ADDR_W-1:0]  mem_addr;
  logic               mem_we;
  logic [COLOR_W-1:0] mem_wdata;

  // step logic
  logic               req_take;
  logic               rsp_free;
  logic               pt_inside;
  logic               area_empty;
  logic               fill_row_end;
  logic               fill_last;
  logic               line_last;
  logic               step_x;
  logic               step_y;
  err_t               dx_s;
  err_t               dy_s;
  err_t               err_next;
  logic [COORD_W-1:0] in_dx;
  logic [COORD_W-1:0] in_dy;
  err_t               err_init;

  // active size saturates at the store dimensions
  assign act_w = (32'(image_width) > MAX_WIDTH) ? SIZE_W'(MAX_WIDTH) : image_width;
  assign act_h = (32'(image_height) > MAX_HEIGHT) ? SIZE_W'(MAX_HEIGHT) : image_height;
  assign area_empty = (act_w == '0) || (act_h == '0);

  // handshake
  assign req_stall = (state != S_IDLE);
  assign req_take  = req_valid && !req_stall;
  assign rsp_free  = !rsp_valid || !rsp_stall;

  // current point
  assign pt_inside = (walk_x < act_w) && (walk_y < act_h);
  assign mem_addr  = ADDR_W'(32'(walk_y) * MAX_WIDTH + 32'(walk_x));

  assign fill_row_end = (walk_x == act_w - SIZE_W'(1));
  assign fill_last    = fill_row_end && (walk_y == act_h - SIZE_W'(1));
  assign line_last    = (walk_x == {1'b0, goal_x}) && (walk_y == {1'b0, goal_y});

  // Bresenham step
  assign dx_s     = $signed({2'b00, delta_x});
  assign dy_s     = $signed({2'b00, delta_y});
  assign step_x   = error_term > (ERR_W'(0) - dx_s);
  assign step_y   = error_term < dy_s;
  assign err_next = error_term - (step_x ? dy_s : err_t'(0)) + (step_y ? dx_s : err_t'(0));

  // line setup from the request fields
  assign in_dx    = (end_x > start_x) ? end_x - start_x : start_x - end_x;
  assign in_dy    = (end_y > start_y) ? end_y - start_y : start_y - end_y;
  assign err_init = (in_dx > in_dy) ? $signed({3'b000, in_dx[COORD_W-1:1]})
                                    : $signed(ERR_W'(0) - {3'b000, in_dy[COORD_W-1:1]});

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= SIZE_W'(64);
      image_height <= SIZE_W'(64);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_take) begin
          case (op_t'(operation))
            OP_FILL: state_next = area_empty ? S_RESULT : S_FILL;
            OP_LINE: state_next = S_LINE;
            OP_READ: state_next = S_READ;
            default: state_next = S_RESULT;
          endcase
        end
      end
      S_FILL:   if (fill_last) state_next = S_RESULT;
      S_LINE:   if (line_last) state_next = S_RESULT;
      S_READ:   state_next = S_RDATA;
      S_RDATA:  state_next = S_RESULT;
      S_RESULT: if (rsp_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // store write control
  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = fill_color;
    case (state)
      S_FILL: mem_we = 1'b1;
      S_LINE: begin
        mem_we    = pt_inside;
        mem_wdata = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // walk and result datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      walk_x     <= '0;
      walk_y     <= '0;
      error_term <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req_take) begin
            res_pix    <= '0;
            res_clip   <= 1'b0;
            res_done   <= (op_t'(operation) != OP_NONE);
            fill_color <= {fill_red, fill_green, fill_blue};
            goal_x     <= end_x;
            goal_y     <= end_y;
            delta_x    <= in_dx;
            delta_y    <= in_dy;
            x_down     <= !(start_x < end_x);
            y_down     <= !(start_y < end_y);
            case (op_t'(operation))
              OP_FILL: begin
                walk_x <= '0;
                walk_y <= '0;
              end
              OP_LINE: begin
                walk_x     <= {1'b0, start_x};
                walk_y     <= {1'b0, start_y};
                error_term <= err_init;
              end
              OP_READ: begin
                walk_x <= {1'b0, start_x};
                walk_y <= {1'b0, start_y};
              end
              default: ;
            endcase
          end
        end
        S_FILL: begin
          if (fill_row_end) begin
            walk_x <= '0;
            walk_y <= walk_y + SIZE_W'(1);
          end else begin
            walk_x <= walk_x + SIZE_W'(1);
          end
        end
        S_LINE: begin
          res_clip <= res_clip | !pt_inside;
          if (!line_last) begin
            error_term <= err_next;
            if (step_x) walk_x <= x_down ? walk_x - SIZE_W'(1) : walk_x + SIZE_W'(1);
            if (step_y) walk_y <= y_down ? walk_y - SIZE_W'(1) : walk_y + SIZE_W'(1);
          end
        end
        S_RDATA: begin
          res_pix  <= pt_inside ? rd_data : '0;
          res_clip <= !pt_inside;
        end
        default: ;
      endcase
    end
  end

  // frame store, one port, registered read
  always_ff @(posedge clk) begin
    if (mem_we) frame_store[mem_addr] <= mem_wdata;
    rd_data <= frame_store[mem_addr];
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == S_RESULT && rsp_free) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_RESULT && rsp_free) begin
      pixel_red   <= res_pix[3*CHAN_W-1:2*CHAN_W];
      pixel_green <= res_pix[2*CHAN_W-1:CHAN_W];
      pixel_blue  <= res_pix[CHAN_W-1:0];
      clipped     <= res_clip;
      done_res    <= res_done;
    end
  end

  // checks
  a_write_in_area: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (walk_x < act_w) && (walk_y < act_h))
    else $error("frame store written outside the active area");

  a_read_latency: assert property (@(posedge clk) disable iff (rst)
    (req_take && op_t'(operation) == OP_READ) |=> ##1 (state == S_RDATA))
    else $error("read request did not reach data stage on time");

  a_rsp_from_result: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state) == S_RESULT)
    else $error("response raised outside the result state");

  a_line_step_moves: assert property (@(posedge clk) disable iff (rst)
    (state == S_LINE && !line_last) |-> (step_x || step_y))
    else $error("line walk stalled on a point");

endmodule
